// ===== sv/itc_pkg.sv =====
// Shared types, codes and sizes for the three-counter interval timer.
// Used by the front end, the back end, the counter cells and the top level.
// Has no dependencies.
package itc_pkg;

  // Number of counters that exist (1 to 3).
  localparam int NUM_CNT = 3;

  // Queue between the front end and the back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Port that carries the control word.
  localparam logic [1:0] PORT_CTRL = 2'd3;

  // Byte access codes.
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  // Operating modes.
  localparam logic [2:0] MODE_INT     = 3'd0;
  localparam logic [2:0] MODE_ONESHOT = 3'd1;
  localparam logic [2:0] MODE_RATE    = 3'd2;
  localparam logic [2:0] MODE_SQUARE  = 3'd3;

  // Item classes decided by the front end.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_LOAD  = 3'd3;
  localparam logic [2:0] OP_LATCH = 3'd4;
  localparam logic [2:0] OP_PROG  = 3'd5;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] sel;
    logic [7:0] data;
  } op_t;

  // Strobes that the back end sends to one counter cell.
  typedef struct packed {
    logic tick;
    logic rd;
    logic load;
    logic latch;
    logic prog;
  } cnt_cmd_t;

endpackage

// ===== sv/itc_front.sv =====
// Front end of the interval timer: accepts items, classifies them and
// queues them for the back end. Depends on itc_pkg.
module itc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [1:0]         port,
  input  logic [7:0]         data,
  input  logic               q_pop,
  output logic               q_valid,
  output itc_pkg::op_t       q_op
);

  itc_pkg::op_t                 dec_op;
  itc_pkg::op_t                 q_mem [itc_pkg::QDEPTH];
  logic [itc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [itc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [itc_pkg::QCNT_W-1:0]   q_count;
  logic                         push;

  // Classify the incoming item; anything aimed at a missing counter becomes a no-op item here.
  always_comb begin
    dec_op.kind = itc_pkg::OP_NONE;
    dec_op.sel  = port;
    dec_op.data = data;
    case (cmd)
      itc_pkg::CMD_TICK: begin
        dec_op.kind = itc_pkg::OP_TICK;
      end
      itc_pkg::CMD_READ: begin
        if (port != itc_pkg::PORT_CTRL && int'(port) < itc_pkg::NUM_CNT) begin
          dec_op.kind = itc_pkg::OP_READ;
        end
      end
      itc_pkg::CMD_WRITE: begin
        if (port == itc_pkg::PORT_CTRL) begin
          dec_op.sel = data[7:6];
          if (data[7:6] != 2'd3 && int'(data[7:6]) < itc_pkg::NUM_CNT) begin
            if (data[5:4] == itc_pkg::ACC_LATCH) begin
              dec_op.kind = itc_pkg::OP_LATCH;
            end else begin
              dec_op.kind = itc_pkg::OP_PROG;
            end
          end
        end else if (int'(port) < itc_pkg::NUM_CNT) begin
          dec_op.kind = itc_pkg::OP_LOAD;
        end
      end
      default: begin
        dec_op.kind = itc_pkg::OP_NONE;
      end
    endcase
  end

  assign in_stall = (q_count == itc_pkg::QCNT_W'(itc_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (q_count != '0);
  assign q_op     = q_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec_op;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        q_count <= q_count + 1'b1;
      end else if (!push && q_pop) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/itc_counter.sv =====
// One counter cell of the interval timer: mode, access state, counts and
// output level, updated by strobes from the back end. Depends on itc_pkg.
module itc_counter (
  input  logic                clk,
  input  logic                rst,
  input  itc_pkg::cnt_cmd_t   ccmd,
  input  logic [7:0]          data,
  output logic [7:0]          rd_byte,
  output logic                out_next
);

  logic [2:0]  op_mode,        op_mode_next;
  logic [1:0]  byte_access,    byte_access_next;
  logic [15:0] live_count,     live_count_next;
  logic [15:0] reload_count,   reload_count_next;
  logic [15:0] held_count,     held_count_next;
  logic        held_flag,      held_flag_next;
  logic        read_high_next, read_high_next_next;
  logic        write_high_next, write_high_next_next;
  logic        counting,       counting_next;
  logic        out_bit,        out_bit_next;

  logic [15:0] src;
  logic [15:0] dec_v;
  logic [15:0] step;
  logic [2:0]  new_mode;
  logic        done;

  assign src      = held_flag ? held_count : live_count;
  assign out_next = out_bit_next;

  // Modes 6 and 7 fold onto 2 and 3.
  always_comb begin
    new_mode = data[3:1];
    if (data[3:2] == 2'b11) begin
      new_mode = data[3:1] ^ 3'b100;
    end
  end

  // Next state for whichever strobe is active.
  always_comb begin
    op_mode_next         = op_mode;
    byte_access_next     = byte_access;
    live_count_next      = live_count;
    reload_count_next    = reload_count;
    held_count_next      = held_count;
    held_flag_next       = held_flag;
    read_high_next_next  = read_high_next;
    write_high_next_next = write_high_next;
    counting_next        = counting;
    out_bit_next         = out_bit;
    rd_byte              = 8'd0;
    dec_v                = live_count - 16'd1;
    step                 = 16'd2;
    done                 = 1'b0;

    if (ccmd.tick) begin
      if (counting) begin
        case (op_mode)
          itc_pkg::MODE_INT: begin
            live_count_next = dec_v;
            if (dec_v == 16'd0) begin
              out_bit_next = 1'b1;
            end
          end
          itc_pkg::MODE_ONESHOT: begin
            if (live_count == 16'd0) begin
              out_bit_next = 1'b1;
            end else begin
              live_count_next = dec_v;
            end
          end
          itc_pkg::MODE_RATE: begin
            if (dec_v <= 16'd1) begin
              out_bit_next    = 1'b0;
              live_count_next = reload_count;
            end else begin
              live_count_next = dec_v;
              if (dec_v == reload_count - 16'd1) begin
                out_bit_next = 1'b1;
              end
            end
          end
          itc_pkg::MODE_SQUARE: begin
            // Odd counts step by one or three so the two half periods add up.
            if (live_count[0]) begin
              step = out_bit ? 16'd1 : 16'd3;
            end
            live_count_next = (live_count > step) ? live_count - step : 16'd0;
            if (live_count_next < 16'd2) begin
              out_bit_next    = ~out_bit;
              live_count_next = reload_count;
            end
          end
          default: begin
            if (out_bit) begin
              live_count_next = dec_v;
              if (dec_v == 16'd0) begin
                out_bit_next = 1'b0;
              end
            end
          end
        endcase
      end
    end else if (ccmd.rd) begin
      case (byte_access)
        itc_pkg::ACC_LOW: begin
          rd_byte        = src[7:0];
          held_flag_next = 1'b0;
        end
        itc_pkg::ACC_HIGH: begin
          rd_byte        = src[15:8];
          held_flag_next = 1'b0;
        end
        itc_pkg::ACC_BOTH: begin
          if (!read_high_next) begin
            rd_byte = src[7:0];
          end else begin
            rd_byte        = src[15:8];
            held_flag_next = 1'b0;
          end
          read_high_next_next = ~read_high_next;
        end
        default: begin
          rd_byte = 8'd0;
        end
      endcase
    end else if (ccmd.load) begin
      if (byte_access != itc_pkg::ACC_LATCH) begin
        held_flag_next  = 1'b0;
        held_count_next = 16'd0;
        case (byte_access)
          itc_pkg::ACC_LOW: begin
            reload_count_next = {8'd0, data};
            done              = 1'b1;
          end
          itc_pkg::ACC_HIGH: begin
            reload_count_next = {data, 8'd0};
            done              = 1'b1;
          end
          default: begin
            if (!write_high_next) begin
              reload_count_next    = {reload_count[15:8], data};
              write_high_next_next = 1'b1;
              if (op_mode == itc_pkg::MODE_INT) begin
                counting_next = 1'b0;
              end
            end else begin
              reload_count_next    = {data, reload_count[7:0]};
              write_high_next_next = 1'b0;
              done                 = 1'b1;
            end
          end
        endcase
        // A complete reload value starts the counter.
        if (done) begin
          live_count_next = reload_count_next;
          counting_next   = 1'b1;
          out_bit_next    = (op_mode >= itc_pkg::MODE_SQUARE);
        end
      end
    end else if (ccmd.latch) begin
      held_flag_next  = 1'b1;
      held_count_next = live_count;
    end else if (ccmd.prog) begin
      byte_access_next     = data[5:4];
      op_mode_next         = new_mode;
      write_high_next_next = 1'b0;
    end
  end

  // Counter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode         <= '0;
      byte_access     <= '0;
      live_count      <= '0;
      reload_count    <= '0;
      held_count      <= '0;
      held_flag       <= 1'b0;
      read_high_next  <= 1'b0;
      write_high_next <= 1'b0;
      counting        <= 1'b0;
      out_bit         <= 1'b0;
    end else begin
      op_mode         <= op_mode_next;
      byte_access     <= byte_access_next;
      live_count      <= live_count_next;
      reload_count    <= reload_count_next;
      held_count      <= held_count_next;
      held_flag       <= held_flag_next;
      read_high_next  <= read_high_next_next;
      write_high_next <= write_high_next_next;
      counting        <= counting_next;
      out_bit         <= out_bit_next;
    end
  end

endmodule

// ===== sv/itc_back.sv =====
// Back end of the interval timer: takes classified items from the queue,
// drives the counter cells and holds the result item. Depends on itc_pkg
// and itc_counter.
module itc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  itc_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic [2:0]         out_levels
);

  itc_pkg::cnt_cmd_t            ccmd   [itc_pkg::NUM_CNT];
  logic [7:0]                   rd_b   [itc_pkg::NUM_CNT];
  logic [itc_pkg::NUM_CNT-1:0]  out_n;
  logic [7:0]                   read_data_next;

  // An item leaves the queue when the result register is free or being taken.
  assign q_pop = q_valid && (!out_valid || !out_stall);

  // One cell per counter; strobes only while an item is popped.
  for (genvar i = 0; i < itc_pkg::NUM_CNT; i++) begin : g_cnt
    logic hit;
    assign hit = q_pop && (q_op.sel == 2'(i));
    assign ccmd[i].tick  = q_pop && (q_op.kind == itc_pkg::OP_TICK);
    assign ccmd[i].rd    = hit && (q_op.kind == itc_pkg::OP_READ);
    assign ccmd[i].load  = hit && (q_op.kind == itc_pkg::OP_LOAD);
    assign ccmd[i].latch = hit && (q_op.kind == itc_pkg::OP_LATCH);
    assign ccmd[i].prog  = hit && (q_op.kind == itc_pkg::OP_PROG);

    itc_counter u_cnt (
      .clk      (clk),
      .rst      (rst),
      .ccmd     (ccmd[i]),
      .data     (q_op.data),
      .rd_byte  (rd_b[i]),
      .out_next (out_n[i])
    );
  end

  // Only the addressed cell drives a nonzero read byte.
  always_comb begin
    read_data_next = 8'd0;
    for (int i = 0; i < itc_pkg::NUM_CNT; i++) begin
      read_data_next = read_data_next | rd_b[i];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      read_data  <= read_data_next;
      out_levels <= 3'(out_n);
    end
  end

endmodule

// ===== sv/interval_timer_three_counters.sv =====
// Top level of the three-counter interval timer. Depends on itc_pkg,
// itc_front and itc_back.
//
// Each input item is a tick, a port read or a port write, and yields exactly one
// result item with the read byte and the three output levels after the item.
// The block takes one item per clock while the queue is not full: an accepted item
// waits in the four-entry queue and is executed by the counter cells in the following
// cycle at the earliest, and its result is registered in that same update; it waits
// longer in the queue while the result side stalls. Input stall rises only when that
// queue is full; the sustained rate is one item per cycle while the result side does
// not stall.
module interval_timer_three_counters (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [1:0] port,
  input  logic [7:0] data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [2:0] out_levels
);

  itc_pkg::op_t q_op;
  logic         q_valid;
  logic         q_pop;

  itc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .port     (port),
    .data     (data),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_op     (q_op)
  );

  itc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .out_levels (out_levels)
  );

endmodule

// ===== sv/itc_checker.sv =====
// Port-level checks for the interval timer, bound to the top level.
// Depends only on the ports of interval_timer_three_counters.
module itc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic [2:0] out_levels
);

  // Reset leaves no result pending and the input open.
  a_reset: assert property (@(posedge clk) rst |=> (!out_valid && !in_stall))
    else $error("result pending or input stalled after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(out_levels)))
    else $error("stalled result changed");

  // The queue can only fill up while the result side is stalled.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // The queue drains only when a result can move on.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> $past(!(out_valid && out_stall)))
    else $error("queue drained while result was stalled");

endmodule

bind interval_timer_three_counters itc_checker u_itc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .out_levels (out_levels)
);
